### hdl/assert_macros.svh
// Assertion macros for the checker module of the beam block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/tksb_pkg.sv
// Package with the word types, command codes and helpers of the score beam.
`timescale 1ns / 1ps

package tksb_pkg;

	localparam int MAX_WIDTH_DEF = 16;
	localparam int CFG_W         = 5;
	localparam int TAG_W         = 16;
	localparam int SCORE_W       = 32;
	localparam int IDX_W         = 4;
	localparam int CNT_OUT_W     = 5;
	localparam logic [CFG_W-1:0] WIDTH_RST = 5'd4;

	typedef enum logic [1:0] {
		CMD_INSERT  = 2'd0,
		CMD_READ    = 2'd1,
		CMD_EXTRACT = 2'd2
	} cmd_e;

	typedef struct packed {
		logic [1:0]                cmd;
		logic [TAG_W-1:0]          new_tag;
		logic signed [SCORE_W-1:0] new_score;
		logic [IDX_W-1:0]          read_index;
	} req_word_t;

	typedef struct packed {
		logic                      status;
		logic [TAG_W-1:0]          out_tag;
		logic signed [SCORE_W-1:0] out_score;
		logic                      dropped_valid;
		logic [TAG_W-1:0]          dropped_tag;
		logic [CNT_OUT_W-1:0]      entry_count;
	} rsp_word_t;

	typedef struct packed {
		logic                      valid;
		logic [TAG_W-1:0]          tag;
		logic signed [SCORE_W-1:0] score;
	} entry_t;

	typedef struct packed {
		logic ins;
		logic clr;
	} cell_ctrl_t;

	// Width register saturated to 1..maxw; zero acts as one.
	function automatic int sat_width(input logic [CFG_W-1:0] v, input int maxw);
		int w;
		w = int'(v);
		if (w < 1) begin
			w = 1;
		end
		if (w > maxw) begin
			w = maxw;
		end
		return w;
	endfunction

endpackage

### hdl/tksb_cell.sv
// One beam slot: holds an entry and takes the new word or its upper neighbor's entry.
`timescale 1ns / 1ps

module tksb_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  tksb_pkg::cell_ctrl_t ctrl,
	input  logic                in_use,
	input  logic                cut,
	input  logic                cond_prev,
	input  tksb_pkg::entry_t    prev_e,
	input  tksb_pkg::entry_t    new_e,
	output logic                cond,
	output tksb_pkg::entry_t    e
);
	import tksb_pkg::*;

	logic                      valid_q;
	logic [TAG_W-1:0]          tag_q;
	logic signed [SCORE_W-1:0] score_q;
	logic                      load;
	entry_t                    load_e;

	// The new entry belongs at or above this slot when the slot is empty or weaker.
	assign cond = in_use && (!valid_q || (score_q < new_e.score));

	always_comb begin
		load   = ctrl.ins && in_use && (cond_prev || cond);
		load_e = cond_prev ? prev_e : new_e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clr || cut) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= load_e.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tag_q   <= load_e.tag;
			score_q <= load_e.score;
		end
	end

	assign e = '{valid: valid_q, tag: tag_q, score: score_q};

endmodule

### hdl/top_k_score_beam_core.sv
// Top level of the sorted score beam: a row of slot cells and a response register.
// The response to an accepted word is registered: it is valid in the cycle after acceptance
// and can be taken at the end of that cycle.
// Throughput: one word per cycle while no response is stalled; every slot compares and
// shifts in the same cycle. The response register frees itself as the response is taken.
// Reset clears all slot valid marks, the count and the response valid; width resets to 4.
`timescale 1ns / 1ps

module top_k_score_beam_core #(
	parameter int MAX_WIDTH = tksb_pkg::MAX_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  tksb_pkg::req_word_t         req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output tksb_pkg::rsp_word_t         rsp,
	input  logic                        cfg_we,
	input  logic [tksb_pkg::CFG_W-1:0]  cfg_wdata
);
	import tksb_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH + 1);

	logic [CFG_W-1:0]     cfg_q;
	logic [CW-1:0]        w_cur;
	logic [CW-1:0]        w_m1;
	logic [CW-1:0]        w_new;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        count_nxt;
	logic                 acc;
	logic                 rsp_valid_q;
	rsp_word_t            rsp_q;
	rsp_word_t            rsp_nxt;
	cell_ctrl_t           ctrl;
	entry_t               new_e;
	entry_t               cell_e [MAX_WIDTH];
	logic [MAX_WIDTH-1:0] cond_vec;
	logic [MAX_WIDTH-1:0] in_use;
	logic [MAX_WIDTH-1:0] cut;
	logic                 last_v;
	logic [TAG_W-1:0]     last_tag;
	logic                 rd_v;
	entry_t               rd_e;
	logic                 any_cond;

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign acc       = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign w_cur = CW'(sat_width(cfg_q, MAX_WIDTH));
	assign w_m1  = w_cur - CW'(1);
	assign w_new = CW'(sat_width(cfg_wdata, MAX_WIDTH));

	assign new_e = '{valid: 1'b1, tag: req.new_tag, score: req.new_score};

	always_comb begin
		ctrl.ins = acc && (cmd_e'(req.cmd) == CMD_INSERT);
		ctrl.clr = acc && (cmd_e'(req.cmd) == CMD_EXTRACT) && cell_e[0].valid;
	end

	for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_cell
		assign in_use[i] = CW'(i) < w_cur;
		assign cut[i]    = cfg_we && (CW'(i) >= w_new);
		if (i == 0) begin : g_head
			tksb_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (ctrl),
				.in_use    (in_use[i]),
				.cut       (cut[i]),
				.cond_prev (1'b0),
				.prev_e    ('0),
				.new_e     (new_e),
				.cond      (cond_vec[i]),
				.e         (cell_e[i])
			);
		end else begin : g_body
			tksb_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (ctrl),
				.in_use    (in_use[i]),
				.cut       (cut[i]),
				.cond_prev (cond_vec[i-1]),
				.prev_e    (cell_e[i-1]),
				.new_e     (new_e),
				.cond      (cond_vec[i]),
				.e         (cell_e[i])
			);
		end
	end

	assign any_cond = |cond_vec;

	// Pick the last slot in use and the slot being read.
	always_comb begin
		last_v   = 1'b0;
		last_tag = '0;
		rd_v     = 1'b0;
		rd_e     = '0;
		for (int i = 0; i < MAX_WIDTH; i++) begin
			if (CW'(i) == w_m1) begin
				last_v   = cell_e[i].valid;
				last_tag = cell_e[i].tag;
			end
			if (i == int'(req.read_index)) begin
				rd_v = cell_e[i].valid;
				rd_e = cell_e[i];
			end
		end
	end

	always_comb begin
		rsp_nxt   = '0;
		count_nxt = count_q;
		unique case (cmd_e'(req.cmd))
			CMD_INSERT: begin
				if (!any_cond) begin
					rsp_nxt.dropped_valid = 1'b1;
					rsp_nxt.dropped_tag   = req.new_tag;
				end else if (last_v) begin
					rsp_nxt.dropped_valid = 1'b1;
					rsp_nxt.dropped_tag   = last_tag;
				end else begin
					count_nxt = count_q + CW'(1);
				end
			end
			CMD_READ: begin
				if (rd_v) begin
					rsp_nxt.out_tag   = rd_e.tag;
					rsp_nxt.out_score = rd_e.score;
				end else begin
					rsp_nxt.status = 1'b1;
				end
			end
			CMD_EXTRACT: begin
				if (cell_e[0].valid) begin
					rsp_nxt.out_tag   = cell_e[0].tag;
					rsp_nxt.out_score = cell_e[0].score;
					count_nxt         = '0;
				end else begin
					rsp_nxt.status = 1'b1;
				end
			end
			default: begin
				rsp_nxt.status = 1'b1;
			end
		endcase
		rsp_nxt.entry_count = CNT_OUT_W'(count_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q   <= WIDTH_RST;
			count_q <= '0;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
			if (count_q > w_new) begin
				count_q <= w_new;
			end
		end else if (acc) begin
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (acc) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rsp_q <= rsp_nxt;
		end
	end

endmodule

### hdl/tksb_checker.sv
// Port-level checker for the score beam, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tksb_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input tksb_pkg::rsp_word_t         rsp,
	input logic                        cfg_we
);
	import tksb_pkg::*;

	// A stalled response word holds.
	`ASSERT_CLK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "response word changed while stalled")
	// Every accepted word gives its response on the next cycle.
	`ASSERT_CLK(a_rsp_next, req_valid && req_ready |=> rsp_valid, "no response after accepted word")
	// An empty response register always takes a word.
	`ASSERT_CLK(a_ready_free, !rsp_valid |-> req_ready, "input stalled with empty response register")
	// Errors carry no entry and no drop report.
	`ASSERT_CLK(a_err_clean, rsp_valid && rsp.status |-> rsp.out_tag == '0 && rsp.out_score == '0 && !rsp.dropped_valid, "error response carries data")
	// The width is only written while no word is offered or waiting.
	`ASSERT_CLK(a_cfg_quiet, cfg_we |-> !req_valid && !rsp_valid, "width written with a word in flight")

endmodule

bind top_k_score_beam_core tksb_checker u_tksb_checker (.*);
